// ===== src/summed_area_window_density_defines.svh =====
// -----------------------------------------------------------------------------
// Summed-area window density: assertion macros
// Shared property forms for the port-level checker.
// -----------------------------------------------------------------------------
`ifndef SUMMED_AREA_WINDOW_DENSITY_DEFINES_SVH
`define SUMMED_AREA_WINDOW_DENSITY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sawd_pkg.sv =====
// -----------------------------------------------------------------------------
// sawd_pkg
// Function codes, register indexes, fixed widths and reset values of the density block.
// -----------------------------------------------------------------------------
`default_nettype none

package sawd_pkg;

    // input function codes
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_RECT = 2'd1;
    localparam logic [1:0] FUNC_TILE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_CELLS = 2'd2;
    localparam logic [1:0] REG_STEP_CELLS   = 2'd3;

    localparam int CFG_W   = 9;   // configuration register width
    localparam int CRD_W   = 13;  // coordinate width for index arithmetic
    localparam int CELLS_W = 18;  // full cell count of a clipped window
    localparam int DIV_STEPS = 48; // quotient bits of (occupancy << 16) / cells

    localparam logic [CFG_W-1:0] RST_GRID_WIDTH   = 9'd256;
    localparam logic [CFG_W-1:0] RST_GRID_HEIGHT  = 9'd256;
    localparam logic [CFG_W-1:0] RST_WINDOW_CELLS = 9'd32;
    localparam logic [CFG_W-1:0] RST_STEP_CELLS   = 9'd16;

endpackage

`default_nettype wire

// ===== src/sawd_table.sv =====
// -----------------------------------------------------------------------------
// sawd_table
// Summed-area table storage: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
`default_nettype none

module sawd_table #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sawd_div.sv =====
// -----------------------------------------------------------------------------
// sawd_div
// Restoring divider, one quotient bit per cycle: (dividend << 16) / divisor,
// saturated to 32 bits.
// -----------------------------------------------------------------------------
`default_nettype none

module sawd_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [31:0]                   dividend,
    input  wire logic [sawd_pkg::CELLS_W-1:0]  divisor,
    output logic                               done,
    output logic [31:0]                        quotient
);

    localparam int NW = sawd_pkg::DIV_STEPS;
    localparam int DW = sawd_pkg::CELLS_W;

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [NW-1:0]   num_reg, num_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 6'(NW - 1);
            num_next = {dividend, 16'd0};
            rem_next = '0;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            num_next = {num_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = (|num_reg[NW-1:32]) ? 32'hFFFF_FFFF : num_reg[31:0];

endmodule

`default_nettype wire

// ===== src/summed_area_window_density.sv =====
// -----------------------------------------------------------------------------
// summed_area_window_density
// Summed-area table builder with rectangle and tile density queries.
// -----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. func selects a
//   cell load (cell_value, raster order), a rectangle query (rect_*) or a tile
//   query (tile_col, tile_row). Queries answer with one result: done is high
//   for exactly one cycle with occupancy, cell_count, density and status.
//   The receiver cannot stall; it must take the result in that cycle.
//   Steps per transaction:
//     load        table read of the entry above, then write-back
//     rectangle   operand setup, clip, four corner reads on one read port
//     tile        as rectangle, then the bit-serial divider, which computes one
//                 quotient bit per cycle; a tile out of range ends after clip
//     func 3      no result
//   Configuration (cfg_we, cfg_index, cfg_data) is written at once, no wait.
//   Reset clears the load position, running row sum and registers to their
//   defaults; the table holds nothing meaningful until the grid is loaded.
// -----------------------------------------------------------------------------
`default_nettype none

module summed_area_window_density #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         func,
    input  wire logic [15:0]        cell_value,
    input  wire logic signed [9:0]  rect_left,
    input  wire logic signed [9:0]  rect_top,
    input  wire logic signed [9:0]  rect_right,
    input  wire logic signed [9:0]  rect_bottom,
    input  wire logic [7:0]         tile_col,
    input  wire logic [7:0]         tile_row,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    output logic                    done,
    output logic [31:0]             occupancy,
    output logic [16:0]             cell_count,
    output logic [31:0]             density,
    output logic                    status
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int RLW   = $clog2(MAX_HEIGHT);
    localparam int CW    = sawd_pkg::CRD_W;
    localparam int FW    = sawd_pkg::CFG_W;
    localparam int NW    = sawd_pkg::CELLS_W;
    localparam int MAXW_SAT = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int MAXH_SAT = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam logic [FW-1:0] MAXW9 = MAXW_SAT[FW-1:0];
    localparam logic [FW-1:0] MAXH9 = MAXH_SAT[FW-1:0];

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LD_WR  = 6'b000010,
        ST_SETUP  = 6'b000100,
        ST_CLIP   = 6'b001000,
        ST_CORNER = 6'b010000,
        ST_DIV    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [FW-1:0] gw_reg, gh_reg, win_reg, step_reg;
    logic [FW-1:0] eff_w, eff_h, eff_win, eff_step;

    // load position
    logic [CLW-1:0] col_reg, col_next;
    logic [RLW-1:0] row_reg, row_next;
    logic [23:0]    rs_reg, rs_next;
    logic [CW-1:0]  col_inc, row_inc;

    // captured transaction
    logic [1:0]        func_reg;
    logic signed [9:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [7:0]        tx_reg, ty_reg;

    // query datapath
    logic [16:0]   ox_reg, oy_reg;
    logic [FW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic          empty_reg, oor_reg;
    logic [NW-1:0] cells_reg;
    logic [2:0]    k_reg, k_next;
    logic          pend_zero_reg, pend_neg_reg;
    logic [31:0]   acc_reg;

    // output
    logic        done_reg, done_next;
    logic [31:0] occ_out_reg, den_out_reg;
    logic [16:0] cnt_out_reg;
    logic        st_out_reg;

    // table ports
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data, rd_data;

    // divider
    logic        div_start, div_done;
    logic [31:0] div_q;

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    function automatic logic [AW-1:0] entry_addr(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // ---------------------------------------------------------------- config
    assign eff_w    = (gw_reg == '0) ? FW'(1) : ((gw_reg > MAXW9) ? MAXW9 : gw_reg);
    assign eff_h    = (gh_reg == '0) ? FW'(1) : ((gh_reg > MAXH9) ? MAXH9 : gh_reg);
    assign eff_win  = (win_reg == '0) ? FW'(1) : win_reg;
    assign eff_step = (step_reg == '0) ? FW'(1) : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= sawd_pkg::RST_GRID_WIDTH;
            gh_reg   <= sawd_pkg::RST_GRID_HEIGHT;
            win_reg  <= sawd_pkg::RST_WINDOW_CELLS;
            step_reg <= sawd_pkg::RST_STEP_CELLS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sawd_pkg::REG_GRID_WIDTH:   gw_reg   <= cfg_data;
                sawd_pkg::REG_GRID_HEIGHT:  gh_reg   <= cfg_data;
                sawd_pkg::REG_WINDOW_CELLS: win_reg  <= cfg_data;
                sawd_pkg::REG_STEP_CELLS:   step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- clip
    logic signed [11:0] rl, rt, rr, rb, sw, sh, cx0, cy0, cx1, cy1;
    logic [17:0]        tx_end, ty_end;
    logic [FW-1:0]      nx0, ny0, nx1, ny1;
    logic               n_empty, n_oor;

    always_comb
    begin
        rl = 12'(left_reg);
        rt = 12'(top_reg);
        rr = 12'(right_reg);
        rb = 12'(bottom_reg);
        sw = 12'(eff_w);
        sh = 12'(eff_h);
        cx0 = (rl < 0) ? 12'sd0 : rl;
        cy0 = (rt < 0) ? 12'sd0 : rt;
        cx1 = (rr > sw) ? sw : rr;
        cy1 = (rb > sh) ? sh : rb;
        tx_end = 18'(ox_reg) + 18'(eff_win);
        ty_end = 18'(oy_reg) + 18'(eff_win);
        if (func_reg == sawd_pkg::FUNC_TILE)
        begin
            n_oor   = (ox_reg >= 17'(eff_w)) || (oy_reg >= 17'(eff_h));
            n_empty = 1'b0;
            nx0 = ox_reg[FW-1:0];
            ny0 = oy_reg[FW-1:0];
            nx1 = (tx_end >= 18'(eff_w)) ? eff_w : tx_end[FW-1:0];
            ny1 = (ty_end >= 18'(eff_h)) ? eff_h : ty_end[FW-1:0];
        end
        else
        begin
            n_oor   = 1'b0;
            n_empty = (cx1 <= cx0) || (cy1 <= cy0);
            nx0 = cx0[FW-1:0];
            ny0 = cy0[FW-1:0];
            nx1 = cx1[FW-1:0];
            ny1 = cy1[FW-1:0];
        end
    end

    // ---------------------------------------------------------------- corners
    logic [FW-1:0] kx, ky;
    logic          k_zero, k_neg;
    logic [31:0]   k_val;
    logic [31:0]   acc_sum;

    assign kx      = k_reg[0] ? x0_reg : x1_reg;
    assign ky      = k_reg[1] ? y0_reg : y1_reg;
    assign k_zero  = empty_reg || (kx == '0) || (ky == '0);
    assign k_neg   = k_reg[0] ^ k_reg[1];
    assign k_val   = pend_zero_reg ? 32'd0 : rd_data;
    assign acc_sum = pend_neg_reg ? (acc_reg - k_val) : (acc_reg + k_val);

    // ---------------------------------------------------------------- table
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept && func == sawd_pkg::FUNC_LOAD && row_reg != '0)
        begin
            rd_en   = 1'b1;
            rd_addr = entry_addr(CW'(col_reg), CW'(row_reg) - CW'(1));
        end
        else if (state_reg == ST_CORNER && !k_reg[2] && !k_zero)
        begin
            rd_en   = 1'b1;
            rd_addr = entry_addr(CW'(kx) - CW'(1), CW'(ky) - CW'(1));
        end
    end

    assign wr_en   = (state_reg == ST_LD_WR);
    assign wr_addr = entry_addr(CW'(col_reg), CW'(row_reg));
    assign wr_data = ((row_reg != '0) ? rd_data : 32'd0) + 32'(rs_reg);

    assign col_inc = CW'(col_reg) + CW'(1);
    assign row_inc = CW'(row_reg) + CW'(1);

    sawd_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // the last corner is still in flight when the divider starts; fold it in
    sawd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  (cells_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        rs_next    = rs_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == sawd_pkg::FUNC_LOAD)
                    begin
                        rs_next    = rs_reg + 24'(cell_value);
                        state_next = ST_LD_WR;
                    end
                    else if (func == sawd_pkg::FUNC_RECT || func == sawd_pkg::FUNC_TILE)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_LD_WR:
            begin
                // advance raster position, wrap row and grid
                if (col_inc >= CW'(eff_w))
                begin
                    col_next = '0;
                    rs_next  = '0;
                    row_next = (row_inc >= CW'(eff_h)) ? '0 : row_inc[RLW-1:0];
                end
                else
                begin
                    col_next = col_inc[CLW-1:0];
                end
                state_next = ST_IDLE;
            end
            ST_SETUP:
            begin
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                k_next = '0;
                if (n_oor)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CORNER;
                end
            end
            ST_CORNER:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    if (func_reg == sawd_pkg::FUNC_TILE)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            rs_reg    <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            rs_reg    <= rs_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            left_reg   <= rect_left;
            top_reg    <= rect_top;
            right_reg  <= rect_right;
            bottom_reg <= rect_bottom;
            tx_reg     <= tile_col;
            ty_reg     <= tile_row;
        end
        if (state_reg == ST_SETUP)
        begin
            ox_reg <= 17'(tx_reg) * 17'(eff_step);
            oy_reg <= 17'(ty_reg) * 17'(eff_step);
        end
        if (state_reg == ST_CLIP)
        begin
            x0_reg    <= nx0;
            y0_reg    <= ny0;
            x1_reg    <= nx1;
            y1_reg    <= ny1;
            empty_reg <= n_empty;
            oor_reg   <= n_oor;
            acc_reg   <= '0;
        end
        if (state_reg == ST_CORNER)
        begin
            pend_zero_reg <= k_zero;
            pend_neg_reg  <= k_neg;
            if (k_reg == 3'd0)
            begin
                cells_reg <= NW'(x1_reg - x0_reg) * NW'(y1_reg - y0_reg);
            end
            else
            begin
                // fold the corner read last cycle into the sum
                acc_reg <= acc_sum;
            end
        end
        if (done_next)
        begin
            if (state_reg == ST_CLIP)
            begin
                occ_out_reg <= '0;
                cnt_out_reg <= '0;
                den_out_reg <= '0;
                st_out_reg  <= 1'b1;
            end
            else if (state_reg == ST_DIV)
            begin
                occ_out_reg <= acc_reg;
                cnt_out_reg <= cells_reg[16:0];
                den_out_reg <= div_q;
                st_out_reg  <= oor_reg;
            end
            else
            begin
                occ_out_reg <= acc_sum;
                cnt_out_reg <= '0;
                den_out_reg <= '0;
                st_out_reg  <= 1'b0;
            end
        end
    end

    assign done       = done_reg;
    assign occupancy  = occ_out_reg;
    assign cell_count = cnt_out_reg;
    assign density    = den_out_reg;
    assign status     = st_out_reg;

endmodule

`default_nettype wire

// ===== src/sawd_checker.sv =====
// -----------------------------------------------------------------------------
// sawd_checker
// Port-level checks of the density block, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "summed_area_window_density_defines.svh"

module sawd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  func,
    input wire logic        done,
    input wire logic [31:0] occupancy,
    input wire logic [31:0] density,
    input wire logic [16:0] cell_count,
    input wire logic        status
);

    `SAWD_ASSERT_NOW(a_done_after_work, done, $past(busy), "result without a transaction in flight")
    `SAWD_ASSERT_NEXT(a_load_no_result, start && !busy && func == sawd_pkg::FUNC_LOAD, busy && !done, "load must hold one cycle and give no result")
    `SAWD_ASSERT_NOW(a_status_clean, done && status, occupancy == 32'd0 && density == 32'd0 && cell_count == 17'd0, "out-of-range tile must report zero fields")

endmodule

bind summed_area_window_density sawd_checker u_sawd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .done       (done),
    .occupancy  (occupancy),
    .density    (density),
    .cell_count (cell_count),
    .status     (status)
);

`default_nettype wire
